// ===== hw/rtl/peq_pkg.sv =====
// ----------------------------------------------------------------------------
// peq_pkg
// Shared types and constants of the priority event queue: the entry layout,
// request kinds, result status codes, sequencer states and compare flags.
// ----------------------------------------------------------------------------
package peq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int SOURCE_BITS = 16;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Source field is carried at the fixed port width; keep only the low
    // SOURCE_BITS.
    localparam logic [15:0] SRC_KEEP =
        (SOURCE_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << SOURCE_BITS) - 32'd1);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_FIND   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PLACE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  code;
        logic [3:0]  priority_lvl;
        logic [15:0] source;
        logic [7:0]  handle;
    } entry_t;

    typedef struct packed {
        logic pri_ge;
        logic hnd_eq;
        logic src_hit;
    } cmp_flags_t;

endpackage

// ===== hw/rtl/peq_store.sv =====
// ----------------------------------------------------------------------------
// peq_store
// Entry memory of the queue: one write port, one read port with registered
// read data.
// ----------------------------------------------------------------------------
module peq_store
    import peq_pkg::*;
(
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/peq_cmp.sv =====
// ----------------------------------------------------------------------------
// peq_cmp
// Shared compare unit: checks one stored entry against the pending request
// for priority order, handle match and source overlap.
// ----------------------------------------------------------------------------
module peq_cmp
    import peq_pkg::*;
(
    input  entry_t      entry,
    input  logic [3:0]  req_priority,
    input  logic [7:0]  req_handle,
    input  logic [15:0] req_mask,
    output cmp_flags_t  flags
);

    always_comb begin
        flags.pri_ge  = (entry.priority_lvl >= req_priority);
        flags.hnd_eq  = (entry.handle == req_handle);
        flags.src_hit = ((entry.source & req_mask) != 16'd0);
    end

endmodule

// ===== hw/rtl/priority_event_queue.sv =====
// ----------------------------------------------------------------------------
// priority_event_queue
// Priority-ordered event store with insert, find by source, remove by handle
// and clear. A sequencer walks the entry memory one entry at a time
// through a single compare unit.
// ----------------------------------------------------------------------------
// Clear and a refused insert go straight to the result state; insert compares
// entries walking down, find and remove read at most occupancy entries.
// One request in flight: a memory read plus a compare per entry step; an
// untaken result word holds the last step.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; memory contents are not cleared, only occupancy.
module priority_event_queue
    import peq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] handle, [23:8] source_bits, [27:24] priority_req,
    // [35:28] event_code, [51:36] match_mask, [55:52] zero
    input  logic [55:0] s_tdata,
    // [1:0] kind
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] found_handle, [23:8] found_source, [27:24] found_priority,
    // [35:28] found_code, [40:36] occupancy, [47:41] zero
    output logic [47:0] m_tdata,
    // [1:0] status
    output logic [1:0]  m_tuser
);

    state_t      state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    kind_t       kind_reg, kind_next;
    entry_t      req_reg, req_next;
    logic [15:0] mask_reg, mask_next;
    logic        found_reg, found_next;
    status_t     stat_reg, stat_next;
    entry_t      hit_reg, hit_next;

    logic        out_valid_reg, out_valid_next;
    logic [47:0] out_data_reg, out_data_next;
    logic [1:0]  out_user_reg, out_user_next;

    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    cmp_flags_t       flags;

    logic             accept;
    logic             out_free;
    kind_t            in_kind;
    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;

    peq_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    peq_cmp u_cmp (
        .entry        (rd_data),
        .req_priority (req_reg.priority_lvl),
        .req_handle   (req_reg.handle),
        .req_mask     (mask_reg),
        .flags        (flags)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign in_kind  = kind_t'(s_tuser);
    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_dec  = idx_reg - CNT_W'(1);

    // Insert walks downward from the top, reading the entry below the hole.
    assign rd_addr = (kind_reg == KIND_INSERT) ? idx_dec[IDX_W-1:0] : idx_reg[IDX_W-1:0];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_kind)
                        KIND_INSERT: begin
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH)) begin
                                state_next = ST_DONE;
                            end else if (cnt_reg == '0) begin
                                state_next = ST_PLACE;
                            end else begin
                                state_next = ST_READ;
                            end
                        end
                        KIND_FIND, KIND_REMOVE: begin
                            state_next = (cnt_reg == '0) ? ST_DONE : ST_READ;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
            end
            ST_READ: state_next = ST_EVAL;
            ST_EVAL: begin
                case (kind_reg)
                    KIND_INSERT: begin
                        if (flags.pri_ge || idx_dec == '0) begin
                            state_next = ST_PLACE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    KIND_FIND: begin
                        if (flags.src_hit || idx_inc == cnt_reg) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_READ;
                        end
                    end
                    default: begin
                        state_next = (idx_inc == cnt_reg) ? ST_DONE : ST_READ;
                    end
                endcase
            end
            ST_PLACE: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        req_next       = req_reg;
        mask_next      = mask_reg;
        found_next     = found_reg;
        stat_next      = stat_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[IDX_W-1:0];
        wr_data        = rd_data;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next            = in_kind;
                    req_next.handle      = s_tdata[7:0];
                    req_next.source      = s_tdata[23:8] & SRC_KEEP;
                    req_next.priority_lvl = s_tdata[27:24];
                    req_next.code        = s_tdata[35:28];
                    mask_next            = s_tdata[51:36] & SRC_KEEP;
                    found_next           = 1'b0;
                    hit_next             = '0;
                    stat_next            = STAT_OK;
                    case (in_kind)
                        KIND_INSERT: begin
                            idx_next = cnt_reg;
                            if (cnt_reg == CNT_W'(QUEUE_DEPTH)) begin
                                stat_next = STAT_FULL;
                            end
                        end
                        KIND_FIND, KIND_REMOVE: begin
                            idx_next = '0;
                            if (cnt_reg == '0) begin
                                stat_next = STAT_NOT_FOUND;
                            end
                        end
                        default: cnt_next = '0;
                    endcase
                end
            end
            ST_EVAL: begin
                case (kind_reg)
                    KIND_INSERT: begin
                        // Move the lower-priority entry up into the hole.
                        if (!flags.pri_ge) begin
                            wr_en    = 1'b1;
                            wr_data  = rd_data;
                            idx_next = idx_dec;
                        end
                    end
                    KIND_FIND: begin
                        if (flags.src_hit) begin
                            hit_next = rd_data;
                        end else begin
                            idx_next = idx_inc;
                            if (idx_inc == cnt_reg) begin
                                stat_next = STAT_NOT_FOUND;
                            end
                        end
                    end
                    default: begin
                        // Past the removed entry, shift each one down a slot.
                        if (found_reg) begin
                            wr_en   = 1'b1;
                            wr_addr = idx_dec[IDX_W-1:0];
                            wr_data = rd_data;
                        end else if (flags.hnd_eq) begin
                            found_next = 1'b1;
                        end
                        idx_next = idx_inc;
                        if (idx_inc == cnt_reg) begin
                            if (found_reg || flags.hnd_eq) begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end else begin
                                stat_next = STAT_NOT_FOUND;
                            end
                        end
                    end
                endcase
            end
            ST_PLACE: begin
                wr_en    = 1'b1;
                wr_data  = req_reg;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_user_next  = stat_reg;
                    out_data_next  = {7'd0, 5'(cnt_reg), hit_reg.code,
                                      hit_reg.priority_lvl, hit_reg.source,
                                      hit_reg.handle};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        kind_reg     <= kind_next;
        req_reg      <= req_next;
        mask_reg     <= mask_next;
        found_reg    <= found_next;
        stat_reg     <= stat_next;
        hit_reg      <= hit_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
